// File: rtl/core/evpcsm_pkg.sv
// Shared types and constants for the control pilot charge state machine.
`timescale 1ns / 1ps

package evpcsm_pkg;

    // Field widths.
    localparam int LEVEL_W  = 12;
    localparam int DUTY_W   = 7;
    localparam int CFG_IDX_W = 2;

    // Commanded PWM duty on entering idle and connected.
    localparam logic [DUTY_W-1:0] DUTY_IDLE      = 7'd100;
    localparam logic [DUTY_W-1:0] DUTY_CONNECTED = 7'd50;

    // Threshold reset values.
    localparam logic [LEVEL_W-1:0] DISCONNECT_RST = 12'd3700;
    localparam logic [LEVEL_W-1:0] CONNECT_RST    = 12'd3400;
    localparam logic [LEVEL_W-1:0] READY_RST      = 12'd2800;
    localparam logic [LEVEL_W-1:0] VENT_RST       = 12'd2100;

    // Charger states.
    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_CONNECTED = 3'd1,
        ST_READY     = 3'd2,
        ST_VENT      = 3'd3,
        ST_FAULT     = 3'd4
    } state_t;

    // Event codes; zero means no event.
    typedef enum logic [3:0] {
        EV_NONE         = 4'd0,
        EV_CONNECTED    = 4'd1,
        EV_DISCONNECTED = 4'd2,
        EV_READY        = 4'd3,
        EV_NOT_READY    = 4'd4,
        EV_VENT_REQ     = 4'd5,
        EV_VENT_CLEAR   = 4'd6,
        EV_FAULT        = 4'd7,
        EV_FAULT_CLEAR  = 4'd8
    } event_t;

    // Input word actions.
    typedef enum logic [1:0] {
        ACT_POST    = 2'd0,
        ACT_MEASURE = 2'd1,
        ACT_STEP    = 2'd2,
        ACT_NOP     = 2'd3
    } action_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISCONNECT = 2'd0,
        CFG_CONNECT    = 2'd1,
        CFG_READY      = 2'd2,
        CFG_VENT       = 2'd3
    } cfg_idx_t;

    // Pilot level thresholds as one group.
    typedef struct packed {
        logic [LEVEL_W-1:0] disconnect_level;
        logic [LEVEL_W-1:0] connect_level;
        logic [LEVEL_W-1:0] ready_level;
        logic [LEVEL_W-1:0] vent_level;
    } thresh_t;

endpackage

// File: rtl/core/evpcsm_level_classify.sv
// Pilot measurement to event classifier.
`timescale 1ns / 1ps

module evpcsm_level_classify
(
    input  logic                         pwm_seen,
    input  logic [evpcsm_pkg::LEVEL_W-1:0] sample_min,
    input  logic [evpcsm_pkg::LEVEL_W-1:0] sample_max,
    input  evpcsm_pkg::thresh_t          thresh,
    output evpcsm_pkg::event_t           meas_event
);

    logic [evpcsm_pkg::LEVEL_W:0]   sample_sum;
    logic [evpcsm_pkg::LEVEL_W-1:0] level;

    // With PWM present the high plateau is the level; otherwise the midpoint.
    assign sample_sum = {1'b0, sample_min} + {1'b0, sample_max};
    assign level      = pwm_seen ? sample_max : sample_sum[evpcsm_pkg::LEVEL_W:1];

    // Thresholds are tested from the highest band down; strictly above selects.
    always_comb
    begin
        if (level > thresh.disconnect_level)
            meas_event = evpcsm_pkg::EV_DISCONNECTED;
        else if (level > thresh.connect_level)
            meas_event = evpcsm_pkg::EV_CONNECTED;
        else if (level > thresh.ready_level)
            meas_event = evpcsm_pkg::EV_READY;
        else if (level > thresh.vent_level)
            meas_event = evpcsm_pkg::EV_VENT_REQ;
        else
            meas_event = evpcsm_pkg::EV_FAULT;
    end

endmodule

// File: rtl/core/ev_pilot_charge_state_machine.sv
// Top level of the charger-side control pilot state machine.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake               Contents
//  input     in         in_valid / in_stall     action, event_code, pwm_seen, samples
//  result    out        out_valid / out_stall   pilot_state, duty_percent, flags
//  config    in         cfg_write               cfg_index, cfg_data (12-bit thresholds)
//
//  Each word waits in the input register until the result slot is free and is
//  resolved into the result register from there, so one word a cycle is
//  sustained while the result is not stalled. The threshold compare chain
//  sets the critical path.
//  Reset puts the machine in idle with 100 percent duty and nothing pending.
//  A stalled result holds the input register; a new word is still taken then
//  while the input register is empty.

module ev_pilot_charge_state_machine
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Input channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          action,
    input  logic [3:0]                          event_code,
    input  logic                                pwm_seen,
    input  logic [evpcsm_pkg::LEVEL_W-1:0]      sample_min,
    input  logic [evpcsm_pkg::LEVEL_W-1:0]      sample_max,
    // Result channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          pilot_state,
    output logic [evpcsm_pkg::DUTY_W-1:0]       duty_percent,
    output logic                                event_rejected,
    output logic                                state_changed,
    // Configuration port.
    input  logic                                cfg_write,
    input  logic [evpcsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [evpcsm_pkg::LEVEL_W-1:0]      cfg_data
);

    // Configuration registers.
    evpcsm_pkg::thresh_t thresh_reg;

    // Input register.
    logic                              in_valid_reg;
    evpcsm_pkg::action_t               action_reg;
    logic [3:0]                        code_reg;
    logic                              pwm_reg;
    logic [evpcsm_pkg::LEVEL_W-1:0]    min_reg;
    logic [evpcsm_pkg::LEVEL_W-1:0]    max_reg;

    // Machine state.
    evpcsm_pkg::state_t                state_reg, state_next, target_state;
    evpcsm_pkg::event_t                pending_code_reg, pending_code_next;
    logic                              pending_valid_reg, pending_valid_next;
    logic [evpcsm_pkg::DUTY_W-1:0]     duty_reg, duty_next;

    // Result register.
    logic                              out_valid_reg, out_valid_next;
    logic                              rejected_reg, rejected_next;
    logic                              changed_reg, changed_next;

    logic                              in_accept;
    logic                              advance;
    logic                              do_step;
    logic                              code_ok;
    evpcsm_pkg::event_t                meas_event;

    // Pipeline control: the input word moves on when the result slot is free.
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // Threshold writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.disconnect_level <= evpcsm_pkg::DISCONNECT_RST;
            thresh_reg.connect_level    <= evpcsm_pkg::CONNECT_RST;
            thresh_reg.ready_level      <= evpcsm_pkg::READY_RST;
            thresh_reg.vent_level       <= evpcsm_pkg::VENT_RST;
        end
        else if (cfg_write)
        begin
            unique case (evpcsm_pkg::cfg_idx_t'(cfg_index))
                evpcsm_pkg::CFG_DISCONNECT: thresh_reg.disconnect_level <= cfg_data;
                evpcsm_pkg::CFG_CONNECT:    thresh_reg.connect_level    <= cfg_data;
                evpcsm_pkg::CFG_READY:      thresh_reg.ready_level      <= cfg_data;
                evpcsm_pkg::CFG_VENT:       thresh_reg.vent_level       <= cfg_data;
                default:                    thresh_reg                  <= thresh_reg;
            endcase
        end
    end

    // Input register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg <= evpcsm_pkg::action_t'(action);
            code_reg   <= event_code;
            pwm_reg    <= pwm_seen;
            min_reg    <= sample_min;
            max_reg    <= sample_max;
        end
    end

    // Measurement classification.
    evpcsm_level_classify u_classify
    (
        .pwm_seen   (pwm_reg),
        .sample_min (min_reg),
        .sample_max (max_reg),
        .thresh     (thresh_reg),
        .meas_event (meas_event)
    );

    // Transition table applied to the pending event.
    always_comb
    begin
        target_state = state_reg;
        unique case (state_reg)
            evpcsm_pkg::ST_IDLE:
            begin
                if (pending_code_reg == evpcsm_pkg::EV_CONNECTED)
                    target_state = evpcsm_pkg::ST_CONNECTED;
                else if (pending_code_reg == evpcsm_pkg::EV_FAULT)
                    target_state = evpcsm_pkg::ST_FAULT;
            end
            evpcsm_pkg::ST_CONNECTED:
            begin
                if (pending_code_reg == evpcsm_pkg::EV_DISCONNECTED)
                    target_state = evpcsm_pkg::ST_IDLE;
                else if (pending_code_reg == evpcsm_pkg::EV_READY)
                    target_state = evpcsm_pkg::ST_READY;
                else if (pending_code_reg == evpcsm_pkg::EV_VENT_REQ)
                    target_state = evpcsm_pkg::ST_VENT;
                else if (pending_code_reg == evpcsm_pkg::EV_FAULT)
                    target_state = evpcsm_pkg::ST_FAULT;
            end
            evpcsm_pkg::ST_READY:
            begin
                if (pending_code_reg == evpcsm_pkg::EV_DISCONNECTED)
                    target_state = evpcsm_pkg::ST_IDLE;
                else if (pending_code_reg == evpcsm_pkg::EV_VENT_REQ)
                    target_state = evpcsm_pkg::ST_VENT;
                else if (pending_code_reg == evpcsm_pkg::EV_NOT_READY)
                    target_state = evpcsm_pkg::ST_CONNECTED;
                else if (pending_code_reg == evpcsm_pkg::EV_FAULT)
                    target_state = evpcsm_pkg::ST_FAULT;
            end
            evpcsm_pkg::ST_VENT:
            begin
                if (pending_code_reg == evpcsm_pkg::EV_DISCONNECTED)
                    target_state = evpcsm_pkg::ST_IDLE;
                else if (pending_code_reg == evpcsm_pkg::EV_VENT_CLEAR)
                    target_state = evpcsm_pkg::ST_CONNECTED;
                else if (pending_code_reg == evpcsm_pkg::EV_FAULT)
                    target_state = evpcsm_pkg::ST_FAULT;
            end
            evpcsm_pkg::ST_FAULT:
            begin
                if (pending_code_reg == evpcsm_pkg::EV_FAULT_CLEAR)
                    target_state = evpcsm_pkg::ST_IDLE;
            end
            default:
                target_state = evpcsm_pkg::ST_FAULT;
        endcase
    end

    // Next state: a step only acts when an event is pending.
    assign do_step    = advance && (action_reg == evpcsm_pkg::ACT_STEP) && pending_valid_reg;
    assign state_next = (do_step) ? target_state : state_reg;

    // Posted codes must name one of the eight events.
    assign code_ok = (code_reg >= 4'(evpcsm_pkg::EV_CONNECTED)) &&
                     (code_reg <= 4'(evpcsm_pkg::EV_FAULT_CLEAR));

    // Outputs of the machine: pending slot, duty and result flags.
    always_comb
    begin
        pending_code_next  = pending_code_reg;
        pending_valid_next = pending_valid_reg;
        duty_next          = duty_reg;
        rejected_next      = rejected_reg;
        changed_next       = changed_reg;
        if (advance)
        begin
            rejected_next = 1'b0;
            changed_next  = 1'b0;
            case (action_reg)
                evpcsm_pkg::ACT_POST:
                begin
                    if (code_ok)
                    begin
                        pending_code_next  = evpcsm_pkg::event_t'(code_reg);
                        pending_valid_next = 1'b1;
                    end
                    else
                        rejected_next = 1'b1;
                end
                evpcsm_pkg::ACT_MEASURE:
                begin
                    pending_code_next  = meas_event;
                    pending_valid_next = 1'b1;
                end
                evpcsm_pkg::ACT_STEP:
                begin
                    if (pending_valid_reg)
                    begin
                        pending_code_next  = evpcsm_pkg::EV_NONE;
                        pending_valid_next = 1'b0;
                        if (target_state != state_reg)
                        begin
                            changed_next = 1'b1;
                            if (target_state == evpcsm_pkg::ST_IDLE)
                                duty_next = evpcsm_pkg::DUTY_IDLE;
                            else if (target_state == evpcsm_pkg::ST_CONNECTED)
                                duty_next = evpcsm_pkg::DUTY_CONNECTED;
                        end
                    end
                end
                default:
                begin
                    pending_code_next = pending_code_reg;
                end
            endcase
        end
    end

    // Result slot valid.
    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= evpcsm_pkg::ST_IDLE;
            pending_code_reg  <= evpcsm_pkg::EV_NONE;
            pending_valid_reg <= 1'b0;
            duty_reg          <= evpcsm_pkg::DUTY_IDLE;
            out_valid_reg     <= 1'b0;
            rejected_reg      <= 1'b0;
            changed_reg       <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            pending_code_reg  <= pending_code_next;
            pending_valid_reg <= pending_valid_next;
            duty_reg          <= duty_next;
            out_valid_reg     <= out_valid_next;
            rejected_reg      <= rejected_next;
            changed_reg       <= changed_next;
        end
    end

    // State and duty only move when a word enters the result slot, so they
    // serve directly as the result fields.
    assign out_valid      = out_valid_reg;
    assign pilot_state    = state_reg;
    assign duty_percent   = duty_reg;
    assign event_rejected = rejected_reg;
    assign state_changed  = changed_reg;

    // Idle always commands full duty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == evpcsm_pkg::ST_IDLE) |-> (duty_reg == evpcsm_pkg::DUTY_IDLE))
        else $error("idle state without full duty");

    // Connected always commands half duty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == evpcsm_pkg::ST_CONNECTED) |-> (duty_reg == evpcsm_pkg::DUTY_CONNECTED))
        else $error("connected state without half duty");

    // The machine holds while no word moves into the result slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg) && $stable(duty_reg))
        else $error("state moved without a word");

    // A step consumes the pending event.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && action_reg == evpcsm_pkg::ACT_STEP) |=> !pending_valid_reg)
        else $error("pending event survived a step");

    // A result never reports both a rejection and a transition.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(rejected_reg && changed_reg))
        else $error("conflicting result flags");

endmodule
